// File: sv/g2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2r_pkg
// types, constants and the 3x5 font rom shared by the glyph run generator
// ----------------------------------------------------------------------------
package g2r_pkg;

    localparam int GLYPH_WIDTH  = 3;
    localparam int GLYPH_HEIGHT = 5;
    localparam int MAX_RUNS     = 10;
    localparam int RUN_IDX_W    = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [4:0] SCALE_MIN = 5'd1;
    localparam logic [4:0] SCALE_MAX = 5'd16;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // configuration register indexes
    localparam logic CFG_PIXEL_SCALE = 1'b0;
    localparam logic CFG_INK_COLOUR  = 1'b1;

    typedef struct packed {
        logic [2:0] row;
        logic [1:0] col;
        logic [1:0] len;
    } t_run;

    typedef struct packed {
        t_run [MAX_RUNS-1:0] runs;
        logic [RUN_IDX_W-1:0] count;
        logic [15:0]          base_x;
        logic [15:0]          base_y;
        logic [4:0]           scale;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic        found;
        logic [14:0] rows;
    } t_glyph;

    typedef struct packed {
        logic [1:0] n;
        logic [1:0] col0;
        logic [1:0] len0;
        logic [1:0] col1;
        logic [1:0] len1;
    } t_row_runs;

    // rows top to bottom, one octal digit per row, msb leftmost
    function automatic t_glyph glyph_rom(input logic [7:0] code);
        t_glyph g;
        g.found = 1'b1;
        unique case (code)
            8'h30: g.rows = 15'o75557;
            8'h31: g.rows = 15'o26227;
            8'h32: g.rows = 15'o71747;
            8'h33: g.rows = 15'o71717;
            8'h34: g.rows = 15'o55711;
            8'h35: g.rows = 15'o74717;
            8'h36: g.rows = 15'o74757;
            8'h37: g.rows = 15'o71111;
            8'h38: g.rows = 15'o75757;
            8'h39: g.rows = 15'o75717;
            8'h41: g.rows = 15'o75755;
            8'h42: g.rows = 15'o65656;
            8'h43: g.rows = 15'o74447;
            8'h44: g.rows = 15'o65556;
            8'h45: g.rows = 15'o74747;
            8'h46: g.rows = 15'o74744;
            8'h47: g.rows = 15'o74557;
            8'h48: g.rows = 15'o55755;
            8'h49: g.rows = 15'o72227;
            8'h4a: g.rows = 15'o11157;
            8'h4b: g.rows = 15'o55655;
            8'h4c: g.rows = 15'o44447;
            8'h4d: g.rows = 15'o57755;
            8'h4e: g.rows = 15'o65555;
            8'h4f: g.rows = 15'o75557;
            8'h50: g.rows = 15'o75744;
            8'h51: g.rows = 15'o75573;
            8'h52: g.rows = 15'o75655;
            8'h53: g.rows = 15'o74717;
            8'h54: g.rows = 15'o72222;
            8'h55: g.rows = 15'o55557;
            8'h56: g.rows = 15'o55552;
            8'h57: g.rows = 15'o55775;
            8'h58: g.rows = 15'o55255;
            8'h59: g.rows = 15'o55222;
            8'h5a: g.rows = 15'o71247;
            8'h3a: g.rows = 15'o02020;
            8'h2d: g.rows = 15'o00700;
            8'h2e: g.rows = 15'o00002;
            8'h2f: g.rows = 15'o11244;
            8'h25: g.rows = 15'o51245;
            8'h3f: g.rows = 15'o71202;
            8'h20: g.rows = 15'o00000;
            default: begin
                g.found = 1'b0;
                g.rows  = 15'o00000;
            end
        endcase
        return g;
    endfunction

    // runs of lit pixels in one 3-pixel row, left to right
    function automatic t_row_runs row_runs(input logic [2:0] p);
        t_row_runs rr;
        rr = '0;
        unique case (p)
            3'b000: rr.n = 2'd0;
            3'b001: begin rr.n = 2'd1; rr.col0 = 2'd2; rr.len0 = 2'd1; end
            3'b010: begin rr.n = 2'd1; rr.col0 = 2'd1; rr.len0 = 2'd1; end
            3'b011: begin rr.n = 2'd1; rr.col0 = 2'd1; rr.len0 = 2'd2; end
            3'b100: begin rr.n = 2'd1; rr.col0 = 2'd0; rr.len0 = 2'd1; end
            3'b101: begin
                rr.n = 2'd2;
                rr.col0 = 2'd0; rr.len0 = 2'd1;
                rr.col1 = 2'd2; rr.len1 = 2'd1;
            end
            3'b110: begin rr.n = 2'd1; rr.col0 = 2'd0; rr.len0 = 2'd2; end
            3'b111: begin rr.n = 2'd1; rr.col0 = 2'd0; rr.len0 = 2'd3; end
            default: rr.n = 2'd0;
        endcase
        return rr;
    endfunction

endpackage

// File: sv/g2r_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2r_front
// folds case, looks up the glyph, lists its runs and computes the glyph origin
// ----------------------------------------------------------------------------
module g2r_front import g2r_pkg::*; (
    input  logic [7:0]  i_character,
    input  logic [7:0]  i_char_index,
    input  logic [12:0] i_origin_x,
    input  logic [12:0] i_origin_y,
    input  logic [4:0]  i_pixel_scale,
    output t_job        o_job,
    output logic        o_has_runs
);

    logic [7:0]           w_code;
    t_glyph               w_glyph;
    logic [4:0]           w_scale;
    logic [12:0]          w_idx_mul;
    t_run [MAX_RUNS-1:0]  w_runs;
    logic [RUN_IDX_W-1:0] w_pos;
    t_row_runs            w_rr;

    assign w_code = (i_character >= CHAR_LOWER_A && i_character <= CHAR_LOWER_Z) ?
                    i_character - CASE_OFFSET : i_character;
    assign w_glyph = glyph_rom(w_code);

    assign w_scale = (i_pixel_scale < SCALE_MIN) ? SCALE_MIN :
                     (i_pixel_scale > SCALE_MAX) ? SCALE_MAX : i_pixel_scale;

    assign w_idx_mul = {5'd0, i_char_index} * {8'd0, w_scale};

    always_comb begin
        w_runs = '0;
        w_pos  = '0;
        w_rr   = '0;
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            w_rr = row_runs(w_glyph.rows[(GLYPH_HEIGHT-1-r)*GLYPH_WIDTH +: GLYPH_WIDTH]);
            if (w_rr.n != 2'd0) begin
                w_runs[w_pos] = '{row: 3'(r), col: w_rr.col0, len: w_rr.len0};
                w_pos = w_pos + 4'd1;
            end
            if (w_rr.n == 2'd2) begin
                w_runs[w_pos] = '{row: 3'(r), col: w_rr.col1, len: w_rr.len1};
                w_pos = w_pos + 4'd1;
            end
        end
    end

    assign o_job.runs   = w_runs;
    assign o_job.count  = w_pos;
    assign o_job.base_x = {{3{i_origin_x[12]}}, i_origin_x} + {1'b0, w_idx_mul, 2'b00};
    assign o_job.base_y = {{3{i_origin_y[12]}}, i_origin_y};
    assign o_job.scale  = w_scale;
    assign o_has_runs   = w_glyph.found && (w_pos != '0);

endmodule

// File: sv/g2r_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2r_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
module g2r_queue import g2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_push, w_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: sv/g2r_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2r_back
// steps through the runs of the head job, one scaled rectangle per cycle
// ----------------------------------------------------------------------------
module g2r_back import g2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  t_q_status   i_status,
    input  logic [15:0] i_ink_colour,
    output logic        o_pop,
    output logic        o_rect_valid,
    output logic [15:0] o_rect_x,
    output logic [15:0] o_rect_y,
    output logic [5:0]  o_rect_width,
    output logic [4:0]  o_rect_height,
    output logic [15:0] o_rect_colour,
    output logic        o_last_rect
);

    logic [RUN_IDX_W-1:0] r_idx, n_idx;
    logic                 w_active;
    logic                 w_last;
    t_run                 w_run;
    logic [6:0]           w_col_off;
    logic [7:0]           w_row_off;
    logic [6:0]           w_len_px;
    logic                 r_valid, r_last;
    logic [15:0]          r_x, r_y, r_colour;
    logic [5:0]           r_width;
    logic [4:0]           r_height;

    assign w_active = !i_status.empty;
    assign w_run    = i_head.runs[r_idx];
    assign w_last   = (r_idx == i_head.count - 4'd1);
    assign o_pop    = w_active && w_last;

    assign w_col_off = {5'd0, w_run.col} * {2'd0, i_head.scale};
    assign w_row_off = {5'd0, w_run.row} * {3'd0, i_head.scale};
    assign w_len_px  = {5'd0, w_run.len} * {2'd0, i_head.scale};

    always_comb begin
        n_idx = r_idx;
        if (w_active) begin
            n_idx = w_last ? '0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= w_active;
            r_last  <= w_active && w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= i_head.base_x + {9'd0, w_col_off};
        r_y      <= i_head.base_y + {8'd0, w_row_off};
        r_width  <= w_len_px[5:0];
        r_height <= i_head.scale;
        r_colour <= i_ink_colour;
    end

    assign o_rect_valid  = r_valid;
    assign o_rect_x      = r_x;
    assign o_rect_y      = r_y;
    assign o_rect_width  = r_width;
    assign o_rect_height = r_height;
    assign o_rect_colour = r_colour;
    assign o_last_rect   = r_last;

endmodule

// File: sv/glyph_to_rect_runs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_to_rect_runs
// 3x5 font character generator emitting one filled rectangle per pixel run
//
// command channel: a character with its string index and string origin is
// taken at a rising edge with start high and busy low. unknown characters and
// blank glyphs are taken and produce nothing.
// result channel: one rectangle per cycle on o_rect_*, marked by o_rect_valid;
// o_last_rect flags the final rectangle of a glyph. the receiver cannot stall.
// flow: an accepted command is written into the job queue; the back end
// registers the rectangles of the head job, one per run (1 to 10 runs).
// throughput: one rectangle per cycle while a job is queued, set by the
// back-end run sequencer; a two-entry job queue lets commands arrive while
// earlier glyphs drain, and busy is high only while that queue is full.
// configuration: index 0 pixel_scale, index 1 ink_colour; o_cfg_ready is
// always high. write only while no rectangle is pending.
// reset: synchronous, active low; queue empty, scale 1, colour 0xffff.
// ----------------------------------------------------------------------------
module glyph_to_rect_runs import g2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_character,
    input  logic [7:0]  i_char_index,
    input  logic [12:0] i_origin_x,
    input  logic [12:0] i_origin_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_rect_valid,
    output logic [15:0] o_rect_x,
    output logic [15:0] o_rect_y,
    output logic [5:0]  o_rect_width,
    output logic [4:0]  o_rect_height,
    output logic [15:0] o_rect_colour,
    output logic        o_last_rect
);

    logic [4:0]  r_pixel_scale;
    logic [15:0] r_ink_colour;
    t_job        w_job;
    logic        w_has_runs;
    logic        w_push;
    t_job        w_head;
    t_q_status   w_status;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_scale <= 5'd1;
            r_ink_colour  <= 16'hffff;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PIXEL_SCALE: r_pixel_scale <= i_cfg_data[4:0];
                CFG_INK_COLOUR:  r_ink_colour  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy   = w_status.full;
    assign w_push = start && !busy && w_has_runs;

    g2r_front u_front (
        .i_character   (i_character),
        .i_char_index  (i_char_index),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_pixel_scale (r_pixel_scale),
        .o_job         (w_job),
        .o_has_runs    (w_has_runs)
    );

    g2r_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    g2r_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_status      (w_status),
        .i_ink_colour  (r_ink_colour),
        .o_pop         (w_pop),
        .o_rect_valid  (o_rect_valid),
        .o_rect_x      (o_rect_x),
        .o_rect_y      (o_rect_y),
        .o_rect_width  (o_rect_width),
        .o_rect_height (o_rect_height),
        .o_rect_colour (o_rect_colour),
        .o_last_rect   (o_last_rect)
    );

    a_rect_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rect_valid |-> (o_rect_width != 6'd0 && o_rect_height != 5'd0))
        else $error("rectangle with zero size");

    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_rect |-> o_rect_valid)
        else $error("last flag without a rectangle");

    a_glyph_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rect_valid && !o_last_rect) |=> o_rect_valid)
        else $error("glyph ended without last flag");

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_status.empty)
        else $error("busy with empty queue");

endmodule
